### rtl/imuoc_pkg.sv
`default_nettype none
package imuoc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 27;
    localparam int WIDE_W   = 28;
    localparam int ERR_W    = 17;
    localparam int DEN_W    = 11;
    localparam int CNT_W    = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 15;
    localparam int AXES     = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_AVERAGED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_DISCARDED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_DEADZONE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_DEADZONE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_COUNTS    = 3'd4;

    localparam logic signed [WIDE_W-1:0] SAMPLE_MAX = WIDE_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [WIDE_W-1:0] SAMPLE_MIN = -SAMPLE_MAX - WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] SUM_MAX    = WIDE_W'((1 << (SUM_W - 1)) - 1);
    localparam logic signed [WIDE_W-1:0] SUM_MIN    = -SUM_MAX - WIDE_W'(1);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
        logic signed [SAMPLE_W-1:0] rate_x;
        logic signed [SAMPLE_W-1:0] rate_y;
        logic signed [SAMPLE_W-1:0] rate_z;
    } imuoc_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] fixed_accel_x;
        logic signed [SAMPLE_W-1:0] fixed_accel_y;
        logic signed [SAMPLE_W-1:0] fixed_accel_z;
        logic signed [SAMPLE_W-1:0] fixed_rate_x;
        logic signed [SAMPLE_W-1:0] fixed_rate_y;
        logic signed [SAMPLE_W-1:0] fixed_rate_z;
        logic                       calibrated;
    } imuoc_out_t;

    // Request to and response from the shared divider.
    typedef struct packed {
        logic                     start;
        logic signed [SUM_W-1:0]  dividend;
        logic        [DEN_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [WIDE_W-1:0] quotient;
    } div_rsp_t;

    // Clamp a wide value to the signed sample range.
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] c;
        c = v;
        if (v > SAMPLE_MAX)
        begin
            c = SAMPLE_MAX;
        end
        else if (v < SAMPLE_MIN)
        begin
            c = SAMPLE_MIN;
        end
        return c[SAMPLE_W-1:0];
    endfunction

    // Clamp a wide value to the signed sum range.
    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] c;
        c = v;
        if (v > SUM_MAX)
        begin
            c = SUM_MAX;
        end
        else if (v < SUM_MIN)
        begin
            c = SUM_MIN;
        end
        return c[SUM_W-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/imuoc_divider.sv
`default_nettype none
module imuoc_divider (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire imuoc_pkg::div_req_t req,
    output imuoc_pkg::div_rsp_t      rsp
);

    localparam int STEP_W = $clog2(imuoc_pkg::SUM_W + 1);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic                              neg_reg, neg_next;
    logic [STEP_W-1:0]                 step_reg, step_next;
    logic [imuoc_pkg::DEN_W-1:0]       rem_reg, rem_next;
    logic [imuoc_pkg::DEN_W-1:0]       dvs_reg, dvs_next;
    logic [imuoc_pkg::SUM_W-1:0]       quo_reg, quo_next;
    logic [imuoc_pkg::DEN_W:0]         trial;
    logic [imuoc_pkg::SUM_W-1:0]       mag_in;
    logic signed [imuoc_pkg::WIDE_W-1:0] q_ext;

    // Magnitude of the dividend; the most negative sum still fits unsigned.
    assign mag_in = req.dividend[imuoc_pkg::SUM_W-1] ? (~req.dividend + 1'b1) : req.dividend;
    assign trial  = {rem_reg, quo_reg[imuoc_pkg::SUM_W-1]};

    // One restoring step per cycle, quotient bits shift in at the bottom.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            neg_next  = req.dividend[imuoc_pkg::SUM_W-1];
            step_next = STEP_W'(imuoc_pkg::SUM_W);
            rem_next  = '0;
            dvs_next  = req.divisor;
            quo_next  = mag_in;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = imuoc_pkg::DEN_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[imuoc_pkg::SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[imuoc_pkg::DEN_W-1:0];
                quo_next = {quo_reg[imuoc_pkg::SUM_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    // Truncation toward zero: negate the magnitude quotient when the dividend is negative (the divisor is unsigned).
    assign q_ext        = signed'({1'b0, quo_reg});
    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -q_ext : q_ext;

endmodule
`default_nettype wire

### rtl/imu_offset_calibration_core.sv
// An ordinary sample is captured, corrected one axis per cycle and then loaded
// into the result register. A sample that closes a calibration pass adds six
// mean divisions on the shared divider, then seeds all six offsets on the first
// pass or runs up to six offset divisions on a later pass. A new sample is taken
// only once the previous result has been loaded into the result register.
// Reset: offsets and sums clear, first pass armed, registers to defaults.
`default_nettype none
module imu_offset_calibration_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output      logic                                  in_stall,
    input  wire imuoc_pkg::imuoc_in_t                  in_data,
    output      logic                                  out_valid,
    input  wire logic                                  out_stall,
    output      imuoc_pkg::imuoc_out_t                 out_data,
    input  wire logic                                  cfg_we,
    input  wire logic [imuoc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [imuoc_pkg::CFG_DAT_W-1:0]       cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_CORR, S_MEAN, S_MEAN_WAIT, S_ADJ, S_ADJ_WAIT, S_FIN
    } state_t;

    typedef logic signed [imuoc_pkg::SAMPLE_W-1:0] smp_t;
    typedef logic signed [imuoc_pkg::SUM_W-1:0]    sum_t;

    state_t state_reg, state_next;
    logic [2:0] axis_reg, axis_next;
    logic [2:0] ready_reg, ready_next;
    logic [imuoc_pkg::CNT_W-1:0] count_reg, count_next;
    logic first_reg, first_next;
    logic done_reg, done_next;
    logic out_valid_reg, out_valid_next;
    imuoc_pkg::imuoc_out_t out_data_reg, out_data_next;
    imuoc_pkg::div_req_t div_req_reg, div_req_next;
    imuoc_pkg::div_rsp_t div_rsp;

    logic [10:0] avg_reg, avg_next;
    logic [9:0]  disc_reg, disc_next;
    logic [7:0]  adz_reg, adz_next;
    logic [7:0]  gdz_reg, gdz_next;
    logic [14:0] grav_reg, grav_next;

    smp_t raw_reg[imuoc_pkg::AXES], raw_next[imuoc_pkg::AXES];
    smp_t fix_reg[imuoc_pkg::AXES], fix_next[imuoc_pkg::AXES];
    smp_t off_reg[imuoc_pkg::AXES], off_next[imuoc_pkg::AXES];
    smp_t mean_reg[imuoc_pkg::AXES], mean_next[imuoc_pkg::AXES];
    sum_t sum_reg[imuoc_pkg::AXES], sum_next[imuoc_pkg::AXES];

    logic [10:0] avg_eff;
    logic [12:0] pass_len;
    logic [12:0] count_inc;
    logic        is_accel;
    smp_t        cur_raw, cur_off, cur_mean;
    sum_t        cur_sum;
    smp_t        corr;
    logic signed [imuoc_pkg::ERR_W-1:0] mean_e, grav_e, err_e, chk_e;
    logic signed [imuoc_pkg::ERR_W-1:0] seed_num, seed_bias, seed_sum;
    smp_t        seed_off;
    logic        [imuoc_pkg::ERR_W-1:0] chk_mag;
    logic        [7:0] tol;
    logic        [imuoc_pkg::DEN_W-1:0] den;
    logic signed [imuoc_pkg::WIDE_W-1:0] off_w;

    imuoc_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    // Per-axis operands chosen by the sequencer.
    assign cur_raw  = raw_reg[axis_reg];
    assign cur_off  = off_reg[axis_reg];
    assign cur_mean = mean_reg[axis_reg];
    assign cur_sum  = sum_reg[axis_reg];
    assign is_accel = (axis_reg < 3'd3);
    assign avg_eff  = (avg_reg == '0) ? 11'd1 : avg_reg;
    assign pass_len = 13'(disc_reg) + 13'(avg_eff);
    assign count_inc = 13'(count_reg) + 13'd1;
    assign corr = imuoc_pkg::sat_sample(imuoc_pkg::WIDE_W'(cur_raw)
                                        + imuoc_pkg::WIDE_W'(cur_off));

    // Deadzone check and divider operands for the offset update.
    assign mean_e  = imuoc_pkg::ERR_W'(cur_mean);
    assign grav_e  = signed'({2'b00, grav_reg});
    assign err_e   = grav_e - mean_e;
    assign chk_e   = (axis_reg == 3'd2) ? err_e : mean_e;
    assign chk_mag = chk_e[imuoc_pkg::ERR_W-1] ? (~chk_e + 1'b1) : chk_e;
    assign tol     = is_accel ? adz_reg : gdz_reg;
    assign off_w   = imuoc_pkg::WIDE_W'(cur_off);

    // First-pass seed: divide by 8 or 4 with truncation toward zero, by a
    // biased arithmetic shift.
    assign seed_num  = (axis_reg == 3'd2) ? err_e : -mean_e;
    assign seed_bias = !seed_num[imuoc_pkg::ERR_W-1] ? '0 :
                       (is_accel ? imuoc_pkg::ERR_W'(7) : imuoc_pkg::ERR_W'(3));
    assign seed_sum  = seed_num + seed_bias;
    assign seed_off  = is_accel ? imuoc_pkg::SAMPLE_W'(seed_sum >>> 3)
                                : imuoc_pkg::SAMPLE_W'(seed_sum >>> 2);

    always_comb
    begin
        if (!is_accel)
        begin
            den = imuoc_pkg::DEN_W'(gdz_reg) + 1'b1;
        end
        else if (adz_reg == '0)
        begin
            den = imuoc_pkg::DEN_W'(1);
        end
        else
        begin
            den = imuoc_pkg::DEN_W'(adz_reg);
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        ready_next     = ready_reg;
        count_next     = count_reg;
        first_next     = first_reg;
        done_next      = done_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        div_req_next   = div_req_reg;
        div_req_next.start = 1'b0;
        avg_next  = avg_reg;
        disc_next = disc_reg;
        adz_next  = adz_reg;
        gdz_next  = gdz_reg;
        grav_next = grav_reg;
        raw_next  = raw_reg;
        fix_next  = fix_reg;
        off_next  = off_reg;
        mean_next = mean_reg;
        sum_next  = sum_reg;

        // Register writes.
        if (cfg_we)
        begin
            case (cfg_index)
                imuoc_pkg::CFG_SAMPLES_AVERAGED:  avg_next  = cfg_data[10:0];
                imuoc_pkg::CFG_SAMPLES_DISCARDED: disc_next = cfg_data[9:0];
                imuoc_pkg::CFG_ACCEL_DEADZONE:    adz_next  = cfg_data[7:0];
                imuoc_pkg::CFG_GYRO_DEADZONE:     gdz_next  = cfg_data[7:0];
                imuoc_pkg::CFG_GRAVITY_COUNTS:    grav_next = cfg_data[14:0];
                default: ;
            endcase
        end

        // Result register empties on its transfer.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    raw_next[0] = in_data.accel_x;
                    raw_next[1] = in_data.accel_y;
                    raw_next[2] = in_data.accel_z;
                    raw_next[3] = in_data.rate_x;
                    raw_next[4] = in_data.rate_y;
                    raw_next[5] = in_data.rate_z;
                    axis_next   = 3'd0;
                    state_next  = S_CORR;
                end
            end
            S_CORR:
            begin
                fix_next[axis_reg] = corr;
                if (!done_reg && (count_reg >= imuoc_pkg::CNT_W'(disc_reg)))
                begin
                    sum_next[axis_reg] = imuoc_pkg::sat_sum(imuoc_pkg::WIDE_W'(cur_sum)
                                                            + imuoc_pkg::WIDE_W'(corr));
                end
                axis_next = axis_reg + 1'b1;
                if (axis_reg == 3'd5)
                begin
                    axis_next = 3'd0;
                    if (done_reg)
                    begin
                        state_next = S_FIN;
                    end
                    else if (count_inc >= pass_len)
                    begin
                        state_next = S_MEAN;
                    end
                    else
                    begin
                        count_next = count_inc[imuoc_pkg::CNT_W-1:0];
                        state_next = S_FIN;
                    end
                end
            end
            S_MEAN:
            begin
                div_req_next.start    = 1'b1;
                div_req_next.dividend = cur_sum;
                div_req_next.divisor  = avg_eff;
                state_next = S_MEAN_WAIT;
            end
            S_MEAN_WAIT:
            begin
                if (div_rsp.done)
                begin
                    mean_next[axis_reg] = imuoc_pkg::sat_sample(div_rsp.quotient);
                    axis_next = axis_reg + 1'b1;
                    state_next = S_MEAN;
                    if (axis_reg == 3'd5)
                    begin
                        axis_next  = 3'd0;
                        ready_next = 3'd0;
                        state_next = S_ADJ;
                    end
                end
            end
            S_ADJ:
            begin
                if (first_reg)
                begin
                    // First pass: seed the offset straight from the mean.
                    off_next[axis_reg] = seed_off;
                    axis_next = axis_reg + 1'b1;
                    if (axis_reg == 3'd5)
                    begin
                        state_next = S_FIN;
                        axis_next  = 3'd0;
                        first_next = 1'b0;
                        sum_next   = '{default: '0};
                        count_next = '0;
                    end
                end
                else if (chk_mag <= imuoc_pkg::ERR_W'(tol))
                begin
                    // Axis within its deadzone: leave the offset alone.
                    ready_next = ready_reg + 1'b1;
                    axis_next  = axis_reg + 1'b1;
                    if (axis_reg == 3'd5)
                    begin
                        state_next = S_FIN;
                        axis_next  = 3'd0;
                        if (ready_reg == 3'd5)
                        begin
                            done_next = 1'b1;
                        end
                        sum_next   = '{default: '0};
                        count_next = '0;
                    end
                end
                else
                begin
                    div_req_next.start    = 1'b1;
                    div_req_next.dividend = imuoc_pkg::SUM_W'(chk_e);
                    div_req_next.divisor  = den;
                    state_next = S_ADJ_WAIT;
                end
            end
            S_ADJ_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (axis_reg == 3'd2)
                    begin
                        off_next[axis_reg] = imuoc_pkg::sat_sample(off_w + div_rsp.quotient);
                    end
                    else
                    begin
                        off_next[axis_reg] = imuoc_pkg::sat_sample(off_w - div_rsp.quotient);
                    end
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_ADJ;
                    if (axis_reg == 3'd5)
                    begin
                        state_next = S_FIN;
                        axis_next  = 3'd0;
                        sum_next   = '{default: '0};
                        count_next = '0;
                    end
                end
            end
            S_FIN:
            begin
                // Load the result once the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next.fixed_accel_x = fix_reg[0];
                    out_data_next.fixed_accel_y = fix_reg[1];
                    out_data_next.fixed_accel_z = fix_reg[2];
                    out_data_next.fixed_rate_x  = fix_reg[3];
                    out_data_next.fixed_rate_y  = fix_reg[4];
                    out_data_next.fixed_rate_z  = fix_reg[5];
                    out_data_next.calibrated    = done_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, configuration and calibration state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= '0;
            ready_reg     <= '0;
            count_reg     <= '0;
            first_reg     <= 1'b1;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            div_req_reg   <= '0;
            avg_reg  <= 11'd1000;
            disc_reg <= 10'd100;
            adz_reg  <= 8'd8;
            gdz_reg  <= 8'd1;
            grav_reg <= 15'd16384;
            off_reg  <= '{default: '0};
            sum_reg  <= '{default: '0};
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            ready_reg     <= ready_next;
            count_reg     <= count_next;
            first_reg     <= first_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
            div_req_reg   <= div_req_next;
            avg_reg  <= avg_next;
            disc_reg <= disc_next;
            adz_reg  <= adz_next;
            gdz_reg  <= gdz_next;
            grav_reg <= grav_next;
            off_reg  <= off_next;
            sum_reg  <= sum_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        raw_reg  <= raw_next;
        fix_reg  <= fix_next;
        mean_reg <= mean_next;
        out_data_reg <= out_data_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

### rtl/imuoc_checker.sv
`default_nettype none
module imuoc_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_stall,
    input wire imuoc_pkg::imuoc_in_t             in_data,
    input wire logic                             out_valid,
    input wire logic                             out_stall,
    input wire imuoc_pkg::imuoc_out_t            out_data,
    input wire logic                             cfg_we,
    input wire logic [imuoc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input wire logic [imuoc_pkg::CFG_DAT_W-1:0]  cfg_data
);

    logic cal_seen_reg, cal_seen_next;
    logic unused_ok;

    assign unused_ok = ^{in_data, cfg_we, cfg_index, cfg_data};

    // Remember a calibrated result once it has been transferred.
    assign cal_seen_next = cal_seen_reg
                           | (out_valid & ~out_stall & out_data.calibrated);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_seen_reg <= 1'b0;
        end
        else
        begin
            cal_seen_reg <= cal_seen_next;
        end
    end

    // Calibration never falls back once reached.
    a_cal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cal_seen_reg) |-> out_data.calibrated)
        else $error("calibrated flag dropped after calibration finished");

    // A sample keeps the block busy for the cycle after its transfer.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken on two consecutive cycles");

    // A sample taken while no result is shown does not bring up a result at once.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !out_valid) |=> !out_valid)
        else $error("result appeared without processing time");

    // A stalled result remains offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result withdrawn while stalled");

endmodule

bind imu_offset_calibration_core imuoc_checker u_imuoc_checker (.*);
`default_nettype wire

### bench/imu_offset_calibration_core_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module imu_offset_calibration_core_tb;

    localparam int WATCHDOG_LIMIT = 6000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    imuoc_pkg::imuoc_in_t in_data;
    logic out_valid;
    logic out_stall;
    imuoc_pkg::imuoc_out_t out_data;
    logic cfg_we;
    logic [imuoc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [imuoc_pkg::CFG_DAT_W-1:0] cfg_data;

    imu_offset_calibration_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock with an 8 ns period.
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Shadow copy of the calibrator: registers and state.
    int unsigned   avg_len;
    int unsigned   drop_len;
    int unsigned   accel_tol;
    int unsigned   gyro_tol;
    int unsigned   gravity;
    longint        axis_sum [imuoc_pkg::AXES];
    longint        axis_off [imuoc_pkg::AXES];
    int unsigned   pass_count;
    bit            seeding;
    bit            cal_done;

    imuoc_pkg::imuoc_out_t corrected_q[$];
    int unsigned   error_count;
    int unsigned   samples_sent;
    int unsigned   results_seen;
    int unsigned   passes_closed;
    int unsigned   idle_cycles;
    int unsigned   receiver_hold;
    bit            sender_steady;
    int unsigned   burst_left;

    function automatic longint clamp(input longint v, input int bits);
        longint lo;
        longint hi;
        lo = -(longint'(1) <<< (bits - 1));
        hi = -lo - 1;
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Close a calibration pass: form the means and seed or nudge the offsets.
    function automatic void close_pass();
        longint n;
        longint mean [imuoc_pkg::AXES];
        longint adiv;
        longint err;
        int ready;
        n = (avg_len != 0) ? longint'(avg_len) : 1;
        for (int i = 0; i < imuoc_pkg::AXES; i++)
        begin
            mean[i] = clamp(axis_sum[i] / n, imuoc_pkg::SAMPLE_W);
        end
        if (seeding)
        begin
            axis_off[0] = clamp(-mean[0] / 8, imuoc_pkg::SAMPLE_W);
            axis_off[1] = clamp(-mean[1] / 8, imuoc_pkg::SAMPLE_W);
            axis_off[2] = clamp((longint'(gravity) - mean[2]) / 8, imuoc_pkg::SAMPLE_W);
            for (int i = 3; i < imuoc_pkg::AXES; i++)
            begin
                axis_off[i] = clamp(-mean[i] / 4, imuoc_pkg::SAMPLE_W);
            end
            seeding = 1'b0;
        end
        else
        begin
            ready = 0;
            adiv = (accel_tol != 0) ? longint'(accel_tol) : 1;
            for (int i = 0; i < 2; i++)
            begin
                if (magnitude(mean[i]) <= longint'(accel_tol))
                begin
                    ready++;
                end
                else
                begin
                    axis_off[i] = clamp(axis_off[i] - mean[i] / adiv, imuoc_pkg::SAMPLE_W);
                end
            end
            err = longint'(gravity) - mean[2];
            if (magnitude(err) <= longint'(accel_tol))
            begin
                ready++;
            end
            else
            begin
                axis_off[2] = clamp(axis_off[2] + err / adiv, imuoc_pkg::SAMPLE_W);
            end
            for (int i = 3; i < imuoc_pkg::AXES; i++)
            begin
                if (magnitude(mean[i]) <= longint'(gyro_tol))
                begin
                    ready++;
                end
                else
                begin
                    axis_off[i] = clamp(axis_off[i] - mean[i] / (longint'(gyro_tol) + 1),
                                        imuoc_pkg::SAMPLE_W);
                end
            end
            if (ready == imuoc_pkg::AXES)
            begin
                cal_done = 1'b1;
            end
        end
        for (int i = 0; i < imuoc_pkg::AXES; i++)
        begin
            axis_sum[i] = 0;
        end
        pass_count = 0;
        passes_closed++;
    endfunction

    // Work out the corrected sample for one raw sample and advance the shadow state.
    function automatic imuoc_pkg::imuoc_out_t correct_sample(input imuoc_pkg::imuoc_in_t s);
        longint raw [imuoc_pkg::AXES];
        longint fixed [imuoc_pkg::AXES];
        int unsigned cnt;
        int unsigned span;
        imuoc_pkg::imuoc_out_t r;
        raw[0] = longint'(s.accel_x);
        raw[1] = longint'(s.accel_y);
        raw[2] = longint'(s.accel_z);
        raw[3] = longint'(s.rate_x);
        raw[4] = longint'(s.rate_y);
        raw[5] = longint'(s.rate_z);
        for (int i = 0; i < imuoc_pkg::AXES; i++)
        begin
            fixed[i] = clamp(raw[i] + axis_off[i], imuoc_pkg::SAMPLE_W);
        end
        if (!cal_done)
        begin
            cnt = pass_count;
            span = (avg_len != 0) ? avg_len : 1;
            if (cnt >= drop_len)
            begin
                for (int i = 0; i < imuoc_pkg::AXES; i++)
                begin
                    axis_sum[i] = clamp(axis_sum[i] + fixed[i], imuoc_pkg::SUM_W);
                end
            end
            cnt++;
            if (cnt >= drop_len + span)
            begin
                close_pass();
            end
            else
            begin
                pass_count = cnt & 12'hFFF;
            end
        end
        r.fixed_accel_x = fixed[0][imuoc_pkg::SAMPLE_W-1:0];
        r.fixed_accel_y = fixed[1][imuoc_pkg::SAMPLE_W-1:0];
        r.fixed_accel_z = fixed[2][imuoc_pkg::SAMPLE_W-1:0];
        r.fixed_rate_x  = fixed[3][imuoc_pkg::SAMPLE_W-1:0];
        r.fixed_rate_y  = fixed[4][imuoc_pkg::SAMPLE_W-1:0];
        r.fixed_rate_z  = fixed[5][imuoc_pkg::SAMPLE_W-1:0];
        r.calibrated    = cal_done;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch on result %0d, %s: got %0d, expected %0d",
                 results_seen, field, got, want);
        error_count++;
    endtask

    // Register write, meant only while the block is idle; the block itself does not enforce this.
    task automatic write_register(input logic [imuoc_pkg::CFG_IDX_W-1:0] idx,
                                  input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[imuoc_pkg::CFG_DAT_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            imuoc_pkg::CFG_SAMPLES_AVERAGED:  avg_len   = value & 11'h7FF;
            imuoc_pkg::CFG_SAMPLES_DISCARDED: drop_len  = value & 10'h3FF;
            imuoc_pkg::CFG_ACCEL_DEADZONE:    accel_tol = value & 8'hFF;
            imuoc_pkg::CFG_GYRO_DEADZONE:     gyro_tol  = value & 8'hFF;
            imuoc_pkg::CFG_GRAVITY_COUNTS:    gravity   = value & 15'h7FFF;
            default: ;
        endcase
    endtask

    // Offer one sample, in bursts with random gaps unless sender_steady is set, and record
    // its expected correction at the transfer.
    task automatic send_sample(input imuoc_pkg::imuoc_in_t s, input bit typed,
                               input imuoc_pkg::imuoc_out_t want);
        imuoc_pkg::imuoc_out_t predicted;
        int unsigned gap;
        if (burst_left == 0 && !sender_steady)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left != 0)
        begin
            burst_left--;
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predicted = correct_sample(s);
        corrected_q.push_back(typed ? want : predicted);
        samples_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (corrected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    function automatic imuoc_pkg::imuoc_in_t random_sample();
        imuoc_pkg::imuoc_in_t s;
        s = imuoc_pkg::imuoc_in_t'({$urandom, $urandom, $urandom});
        // Pull some axes to the rails so that saturation is reached often.
        for (int i = 0; i < imuoc_pkg::AXES; i++)
        begin
            case ($urandom_range(0, 7))
                0: s[i*imuoc_pkg::SAMPLE_W +: imuoc_pkg::SAMPLE_W] = 16'sh7FFF;
                1: s[i*imuoc_pkg::SAMPLE_W +: imuoc_pkg::SAMPLE_W] = 16'sh8000;
                default: ;
            endcase
        end
        return s;
    endfunction

    // Receiver stall pattern: a long hold-off on request wins, else no stalls while bit 8 of samples_sent is set.
    always @(posedge clk)
    begin
        if (receiver_hold != 0)
        begin
            out_stall <= 1'b1;
            receiver_hold <= receiver_hold - 1;
        end
        else if (samples_sent[8])
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 9) < 4);
        end
    end

    // Check each result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        imuoc_pkg::imuoc_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (corrected_q.size() == 0)
            begin
                $display("unexpected result transfer");
                error_count++;
            end
            else
            begin
                want = corrected_q.pop_front();
                if (out_data.fixed_accel_x !== want.fixed_accel_x)
                    report_mismatch("fixed_accel_x", out_data.fixed_accel_x, want.fixed_accel_x);
                if (out_data.fixed_accel_y !== want.fixed_accel_y)
                    report_mismatch("fixed_accel_y", out_data.fixed_accel_y, want.fixed_accel_y);
                if (out_data.fixed_accel_z !== want.fixed_accel_z)
                    report_mismatch("fixed_accel_z", out_data.fixed_accel_z, want.fixed_accel_z);
                if (out_data.fixed_rate_x !== want.fixed_rate_x)
                    report_mismatch("fixed_rate_x", out_data.fixed_rate_x, want.fixed_rate_x);
                if (out_data.fixed_rate_y !== want.fixed_rate_y)
                    report_mismatch("fixed_rate_y", out_data.fixed_rate_y, want.fixed_rate_y);
                if (out_data.fixed_rate_z !== want.fixed_rate_z)
                    report_mismatch("fixed_rate_z", out_data.fixed_rate_z, want.fixed_rate_z);
                if (out_data.calibrated !== want.calibrated)
                    report_mismatch("calibrated", out_data.calibrated, want.calibrated);
            end
            results_seen++;
        end
    end

    // Watchdog: cycles without any transfer on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout with %0d results outstanding", corrected_q.size());
            $display("tb: failure");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Directed rows: after reset the offsets are zero, so each sample comes back unchanged.
    typedef struct {
        imuoc_pkg::imuoc_in_t sample;
        bit                   typed;
    } sample_row_t;

    sample_row_t directed [] = '{
        '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 1'b1},
        '{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b1},
        '{'{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000}, 1'b1},
        '{'{16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF}, 1'b1},
        '{'{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA}, 1'b1},
        '{'{16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555}, 1'b1},
        '{'{16'sh0001, 16'sh8000, 16'sh7FFF, 16'shFFFF, 16'sh4000, 16'shC000}, 1'b1},
        '{'{16'sh0000, 16'sh0000, 16'sh4000, 16'sh0000, 16'sh0000, 16'sh0000}, 1'b1}
    };

    initial
    begin
        imuoc_pkg::imuoc_in_t s;
        imuoc_pkg::imuoc_out_t unused;
        imuoc_pkg::imuoc_out_t want;
        longint base [imuoc_pkg::AXES];
        int unsigned budget;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_stall  = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        error_count = 0;
        samples_sent = 0;
        results_seen = 0;
        passes_closed = 0;
        idle_cycles = 0;
        receiver_hold = 0;
        sender_steady = 1'b0;
        burst_left = 0;
        unused = '0;

        avg_len = 1000;
        drop_len = 100;
        accel_tol = 8;
        gyro_tol = 1;
        gravity = 16384;
        for (int i = 0; i < imuoc_pkg::AXES; i++)
        begin
            axis_sum[i] = 0;
            axis_off[i] = 0;
        end
        pass_count = 0;
        seeding = 1'b1;
        cal_done = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under reset defaults; the pass is left open.
        foreach (directed[k])
        begin
            want = {directed[k].sample, 1'b0};
            send_sample(directed[k].sample, directed[k].typed, want);
        end
        drain_results();

        // Zero averaging count and zero deadzones: the open pass ends with the next sample and
        // every later sample closes a pass of its own, driving offsets to the rails.
        write_register(imuoc_pkg::CFG_SAMPLES_AVERAGED, 0);
        write_register(imuoc_pkg::CFG_SAMPLES_DISCARDED, 0);
        write_register(imuoc_pkg::CFG_ACCEL_DEADZONE, 0);
        write_register(imuoc_pkg::CFG_GYRO_DEADZONE, 0);
        write_register(imuoc_pkg::CFG_GRAVITY_COUNTS, 32767);
        for (int k = 0; k < 40; k++)
        begin
            send_sample(random_sample(), 1'b0, unused);
        end
        drain_results();

        // Short passes with a steady sensor plus noise, until calibration completes or 900 samples are sent.
        write_register(imuoc_pkg::CFG_SAMPLES_AVERAGED, 4);
        write_register(imuoc_pkg::CFG_SAMPLES_DISCARDED, 2);
        write_register(imuoc_pkg::CFG_ACCEL_DEADZONE, 8);
        write_register(imuoc_pkg::CFG_GYRO_DEADZONE, 2);
        write_register(imuoc_pkg::CFG_GRAVITY_COUNTS, 16384);
        for (int i = 0; i < imuoc_pkg::AXES; i++)
        begin
            base[i] = longint'($urandom_range(0, 8000)) - 4000;
        end
        budget = 0;
        while (!cal_done && budget < 900)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                s = random_sample();
            end
            else
            begin
                for (int i = 0; i < imuoc_pkg::AXES; i++)
                begin
                    s[(imuoc_pkg::AXES-1-i)*imuoc_pkg::SAMPLE_W +: imuoc_pkg::SAMPLE_W] =
                        imuoc_pkg::SAMPLE_W'(base[i] + longint'($urandom_range(0, 6)) - 3);
                end
            end
            send_sample(s, 1'b0, unused);
            budget++;
        end
        drain_results();

        // Calibration frozen: register writes at the extremes must not restart it.
        write_register(imuoc_pkg::CFG_SAMPLES_AVERAGED, 2047);
        write_register(imuoc_pkg::CFG_SAMPLES_DISCARDED, 1023);
        write_register(imuoc_pkg::CFG_ACCEL_DEADZONE, 255);
        write_register(imuoc_pkg::CFG_GYRO_DEADZONE, 255);
        write_register(imuoc_pkg::CFG_GRAVITY_COUNTS, 1);

        // Long receiver hold-off while samples keep coming, so the block backs up.
        receiver_hold = 300;
        sender_steady = 1'b1;
        for (int k = 0; k < 60; k++)
        begin
            send_sample(random_sample(), 1'b0, unused);
        end
        sender_steady = 1'b0;
        drain_results();

        write_register(imuoc_pkg::CFG_SAMPLES_AVERAGED, 1);
        write_register(imuoc_pkg::CFG_GRAVITY_COUNTS, 16384);
        while (samples_sent < 1500)
        begin
            send_sample(random_sample(), 1'b0, unused);
        end
        drain_results();

        $display("run covered %0d samples, %0d calibration passes, calibration %s",
                 samples_sent, passes_closed, cal_done ? "completed" : "still open");
        $display("results checked: %0d, mismatches: %0d", results_seen, error_count);
        if (error_count == 0 && corrected_q.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
`default_nettype wire

### filelist.f
rtl/imuoc_pkg.sv
rtl/imuoc_divider.sv
rtl/imu_offset_calibration_core.sv
rtl/imuoc_checker.sv
bench/imu_offset_calibration_core_tb.sv
